@@ rtl/bcl_pkg.sv @@
// ----------------------------------------------------------------------------
// bcl_pkg
// Shared types and constants for the bounded compacting list.
// ----------------------------------------------------------------------------
package bcl_pkg;

    localparam int MAX_WORDS = 64;
    localparam int WORD_W    = 32;
    localparam int CAP_W     = 7;
    localparam int POS_W     = 6;
    localparam int REP_W     = 7;
    localparam int LEN_W     = 7;
    localparam int ADDR_W    = $clog2(MAX_WORDS);
    localparam int CNT_W     = $clog2(MAX_WORDS + 1);

    // Common width for comparing counts, positions and the capacity register
    localparam int CMP_A = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int CMP_B = (POS_W > REP_W) ? POS_W : REP_W;
    localparam int CMP_W = (CMP_A > CMP_B) ? CMP_A : CMP_B;

    localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(64);
    localparam logic [WORD_W-1:0] NEG_ONE   = '1;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_FILL   = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd                     command;
        logic signed [WORD_W-1:0] value;
        logic [POS_W-1:0]         position;
        logic [REP_W-1:0]         repeat_count;
    } t_in_item;

    typedef struct packed {
        logic                     ok;
        logic signed [WORD_W-1:0] data;
        logic [LEN_W-1:0]         length;
    } t_out_item;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSERT,
        OP_READ,
        OP_READ_DONE,
        OP_FILL_SET,
        OP_FILL,
        OP_SEARCH,
        OP_SHIFT
    } t_dp_op;

    typedef struct packed {
        logic   load_item;
        t_dp_op op;
        logic   out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic found;
        logic scan_end;
        logic fill_end;
    } t_dp_stat;

endpackage

@@ rtl/bcl_ram.sv @@
// ----------------------------------------------------------------------------
// bcl_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bcl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/bcl_dp.sv @@
// ----------------------------------------------------------------------------
// bcl_dp
// Datapath: word store, length and capacity registers, scan counters and
// the result registers.
// ----------------------------------------------------------------------------
module bcl_dp (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  bcl_pkg::t_dp_cmd         i_cmd,
    input  bcl_pkg::t_in_item        i_item,
    input  logic                     i_cfg_we,
    input  logic [bcl_pkg::CAP_W-1:0] i_cfg_data,
    output bcl_pkg::t_dp_stat        o_stat,
    output bcl_pkg::t_out_item       o_out_item
);
    import bcl_pkg::*;

    t_in_item          r_item;
    logic [CNT_W-1:0]  r_count;
    logic [CAP_W-1:0]  r_cap;
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_pidx;
    logic [CNT_W-1:0]  r_lim;
    logic              r_pend;
    logic              r_hit;
    t_out_item         r_res;
    t_out_item         r_out;

    logic [CNT_W-1:0]  cap_eff;
    logic [CNT_W-1:0]  fill_lim;
    logic              ins_ok;
    logic              rd_hit;
    logic              issue;
    logic              match;
    logic              val_neg1;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    always_comb begin
        cap_eff = (CMP_W'(r_cap) > CMP_W'(MAX_WORDS)) ? CNT_W'(MAX_WORDS) : CNT_W'(r_cap);
        fill_lim = (CMP_W'(r_item.repeat_count) > CMP_W'(cap_eff)) ?
                   cap_eff : CNT_W'(r_item.repeat_count);
        val_neg1 = (r_item.value == NEG_ONE);
        ins_ok   = (r_count < cap_eff) && !val_neg1;
        rd_hit   = (CMP_W'(r_item.position) < CMP_W'(r_count));
        issue    = (r_idx < r_count);
        match    = r_pend && (ram_rdata == r_item.value);
    end

    assign o_stat.found    = match;
    assign o_stat.scan_end = !r_pend && !issue;
    assign o_stat.fill_end = !(r_idx < r_lim);

    // RAM port steering
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = ADDR_W'(r_idx);
        ram_wdata = r_item.value;
        ram_raddr = ADDR_W'(r_idx);
        case (i_cmd.op)
            OP_INSERT: begin
                ram_we    = ins_ok;
                ram_waddr = ADDR_W'(r_count);
            end
            OP_READ: begin
                ram_raddr = ADDR_W'(r_item.position);
            end
            OP_FILL: begin
                ram_we = (r_idx < r_lim);
            end
            OP_SHIFT: begin
                // move the word read last cycle down one place
                ram_we    = r_pend;
                ram_waddr = ADDR_W'(r_pidx - CNT_W'(1));
                ram_wdata = ram_rdata;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    bcl_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_cap   <= CAP_RESET;
            r_pend  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.load_item) begin
                r_item <= i_item;
                r_idx  <= '0;
                r_pend <= 1'b0;
            end
            case (i_cmd.op)
                OP_INSERT: begin
                    r_count      <= r_count + CNT_W'(ins_ok);
                    r_res.ok     <= ins_ok;
                    r_res.data   <= '0;
                    r_res.length <= LEN_W'(r_count + CNT_W'(ins_ok));
                end
                OP_READ: begin
                    r_hit <= rd_hit;
                end
                OP_READ_DONE: begin
                    r_res.ok     <= r_hit;
                    r_res.data   <= r_hit ? ram_rdata : NEG_ONE;
                    r_res.length <= LEN_W'(r_count);
                end
                OP_FILL_SET: begin
                    r_lim <= val_neg1 ? '0 : fill_lim;
                    r_idx <= '0;
                end
                OP_FILL: begin
                    if (r_idx < r_lim) begin
                        r_idx <= r_idx + CNT_W'(1);
                    end else begin
                        r_count      <= r_lim;
                        r_res.ok     <= !val_neg1;
                        r_res.data   <= '0;
                        r_res.length <= LEN_W'(r_lim);
                    end
                end
                OP_SEARCH: begin
                    if (match) begin
                        // start the shift at the word after the hit
                        r_idx  <= r_pidx + CNT_W'(1);
                        r_pend <= 1'b0;
                    end else begin
                        r_pend <= issue;
                        r_pidx <= r_idx;
                        if (issue) begin
                            r_idx <= r_idx + CNT_W'(1);
                        end
                        if (!r_pend && !issue) begin
                            r_res.ok     <= 1'b0;
                            r_res.data   <= '0;
                            r_res.length <= LEN_W'(r_count);
                        end
                    end
                end
                OP_SHIFT: begin
                    r_pend <= issue;
                    r_pidx <= r_idx;
                    if (issue) begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                    if (!r_pend && !issue) begin
                        r_count      <= r_count - CNT_W'(1);
                        r_res.ok     <= 1'b1;
                        r_res.data   <= '0;
                        r_res.length <= LEN_W'(r_count - CNT_W'(1));
                    end
                end
                default: begin
                    r_hit <= r_hit;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_item = r_out;

endmodule

@@ rtl/bcl_ctrl.sv @@
// ----------------------------------------------------------------------------
// bcl_ctrl
// Command sequencer: steps the datapath through each command and owns the
// input and output handshakes.
// ----------------------------------------------------------------------------
module bcl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  bcl_pkg::t_cmd     i_in_cmd,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  bcl_pkg::t_dp_stat i_stat,
    output bcl_pkg::t_dp_cmd  o_cmd
);
    import bcl_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS,
        S_RD,
        S_RDW,
        S_FSET,
        S_FILL,
        S_SRCH,
        S_SHIFT,
        S_DONE
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_vld;
    logic    n_out_vld;
    t_dp_cmd cmd;
    logic    in_accept;
    logic    out_free;

    assign in_accept = (r_state == S_IDLE) && i_in_valid;
    assign out_free  = !r_out_vld || !i_out_stall;

    always_comb begin
        n_state       = r_state;
        cmd.load_item = in_accept;
        cmd.op        = OP_NONE;
        cmd.out_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_cmd)
                        CMD_INSERT: n_state = S_INS;
                        CMD_REMOVE: n_state = S_SRCH;
                        CMD_READ:   n_state = S_RD;
                        CMD_FILL:   n_state = S_FSET;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_INS: begin
                cmd.op  = OP_INSERT;
                n_state = S_DONE;
            end
            S_RD: begin
                cmd.op  = OP_READ;
                n_state = S_RDW;
            end
            S_RDW: begin
                cmd.op  = OP_READ_DONE;
                n_state = S_DONE;
            end
            S_FSET: begin
                cmd.op  = OP_FILL_SET;
                n_state = S_FILL;
            end
            S_FILL: begin
                cmd.op = OP_FILL;
                if (i_stat.fill_end) begin
                    n_state = S_DONE;
                end
            end
            S_SRCH: begin
                cmd.op = OP_SEARCH;
                if (i_stat.found) begin
                    n_state = S_SHIFT;
                end else if (i_stat.scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                cmd.op = OP_SHIFT;
                if (i_stat.scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold the result until the output register frees up
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (cmd.out_load) begin
            n_out_vld = 1'b1;
        end else if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_cmd       = cmd;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_out_stall) |-> !cmd.out_load)
        else $error("result overwritten while output stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state != S_IDLE))
        else $error("accepted word not processed");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> r_out_vld)
        else $error("result loaded but not presented");

    a_one_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (cmd.op == OP_NONE) && !cmd.load_item)
        else $error("result load overlaps datapath work");

endmodule

@@ rtl/bounded_compacting_list.sv @@
// ----------------------------------------------------------------------------
// bounded_compacting_list
// Densely packed list of 32-bit words with insert, remove, read and fill.
//
//   channel   direction  handshake              payload
//   in        input      i_in_valid/o_in_stall  i_in_item  (t_in_item)
//   out       output     o_out_valid/i_out_stall o_out_item (t_out_item)
//   cfg       input      i_cfg_valid/o_cfg_ready i_cfg_data (capacity)
//
// One word at a time. Remove runs a search and then a shift that together
// step once through the store, one entry a cycle over its single read port.
// A finished result waits in the output register; the next word is taken
// while it waits and held only at its own end if the output is still stalled.
// Reset (synchronous, active low) empties the list and sets capacity to 64;
// store contents are left as they are.
// ----------------------------------------------------------------------------
module bounded_compacting_list (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  bcl_pkg::t_in_item         i_in_item,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output bcl_pkg::t_out_item        o_out_item,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [bcl_pkg::CAP_W-1:0] i_cfg_data
);
    import bcl_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    assign o_cfg_ready = 1'b1;

    bcl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_cmd    (i_in_item.command),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    bcl_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .i_item     (i_in_item),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_stat     (dp_stat),
        .o_out_item (o_out_item)
    );

endmodule
